### hdl/wtsp_pkg.sv
// Package for the world-to-screen projection core: item structs, register
// indexes and the fixed-point widths shared by all modules. No dependencies.
package wtsp_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // The clip sums stay below 2^48 in magnitude, so 49 signed bits hold them.
  localparam int ACC_BITS  = 49;
  localparam int MAG_BITS  = 48;
  localparam int Q_BITS    = 48;
  localparam int NDC_BITS  = 49;
  localparam int HALF_BITS = 14;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_VIEWPORT_WIDTH  = 2'd0;
  localparam cfg_index_t CFG_VIEWPORT_HEIGHT = 2'd1;
  localparam cfg_index_t CFG_NEAR_LIMIT      = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_XFORM = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [3:0]         matrix_index;
    logic signed [31:0] matrix_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } req_t;

  typedef struct packed {
    logic               on_screen;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } rsp_t;

  // Per-item flags that ride alongside the divider.
  typedef struct packed {
    logic on;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } div_side_t;

endpackage

### hdl/wtsp_clip.sv
// Matrix store and clip-space stages: products, sums, near test and divider
// operand setup. Depends on wtsp_pkg.
module wtsp_clip (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                load_en,
  input  logic [3:0]                          load_index,
  input  logic signed [31:0]                  load_value,
  input  logic                                in_valid,
  input  logic signed [31:0]                  pos_x,
  input  logic signed [31:0]                  pos_y,
  input  logic signed [31:0]                  pos_z,
  input  logic [30:0]                         near_limit,
  output logic                                out_valid,
  output wtsp_pkg::div_side_t                 out_side,
  output logic [wtsp_pkg::MAG_BITS-1:0]       out_mag_x,
  output logic [wtsp_pkg::MAG_BITS-1:0]       out_mag_y,
  output logic [wtsp_pkg::MAG_BITS-1:0]       out_w
);

  logic signed [31:0] view_matrix [16];
  logic signed [63:0] prod [3][3];
  logic signed [31:0] trans [3];
  logic               v1;
  logic signed [wtsp_pkg::ACC_BITS-1:0] acc [3];
  logic               v2;
  logic signed [wtsp_pkg::ACC_BITS-1:0] acc_next [3];
  logic signed [31:0] pos [3];

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) view_matrix[i] <= '0;
    end else if (load_en) begin
      view_matrix[load_index] <= load_value;
    end
  end

  // Stage 1: one multiplier per matrix entry used (rows x, y and w).
  for (genvar j = 0; j < 3; j++) begin : g_row
    localparam int R = (j == 2) ? 3 : j;
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) prod[j][c] <= view_matrix[4*c+R] * pos[c];
      end
    end
    always_ff @(posedge clk) begin
      if (en) trans[j] <= view_matrix[12+R];
    end
    // Products are floored to Q16.16 by dropping the low fraction bits.
    assign acc_next[j] =
        wtsp_pkg::ACC_BITS'(trans[j])
      + wtsp_pkg::ACC_BITS'($signed(prod[j][0][63:wtsp_pkg::FRAC_BITS]))
      + wtsp_pkg::ACC_BITS'($signed(prod[j][1][63:wtsp_pkg::FRAC_BITS]))
      + wtsp_pkg::ACC_BITS'($signed(prod[j][2][63:wtsp_pkg::FRAC_BITS]));
    always_ff @(posedge clk) begin
      if (en) acc[j] <= acc_next[j];
    end
  end

  // Stage 3 operands.
  logic                               on_c;
  logic [wtsp_pkg::MAG_BITS-1:0]      mx_c, my_c, w_c;
  logic signed [wtsp_pkg::ACC_BITS-1:0] neg_x, neg_y;

  always_comb begin
    on_c  = (acc[2] > 0) && (acc[2] >= $signed({18'b0, near_limit}));
    neg_x = -acc[0];
    neg_y = -acc[1];
    mx_c  = acc[0][wtsp_pkg::ACC_BITS-1] ? neg_x[wtsp_pkg::MAG_BITS-1:0]
                                         : acc[0][wtsp_pkg::MAG_BITS-1:0];
    my_c  = acc[1][wtsp_pkg::ACC_BITS-1] ? neg_y[wtsp_pkg::MAG_BITS-1:0]
                                         : acc[1][wtsp_pkg::MAG_BITS-1:0];
    w_c   = acc[2][wtsp_pkg::MAG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side.on    <= on_c;
      out_side.neg_x <= acc[0][wtsp_pkg::ACC_BITS-1];
      out_side.neg_y <= acc[1][wtsp_pkg::ACC_BITS-1];
      // A quotient of 2^48 or more shows up as the top dividend bits
      // already reaching the divisor.
      out_side.ovf_x <= {32'b0, mx_c[47:32]} >= w_c;
      out_side.ovf_y <= {32'b0, my_c[47:32]} >= w_c;
      out_mag_x      <= mx_c;
      out_mag_y      <= my_c;
      out_w          <= on_c ? w_c : 48'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

### hdl/wtsp_div.sv
// Pipelined restoring divider for the x and y numerators over a shared w,
// one quotient bit per stage. Depends on wtsp_pkg.
module wtsp_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  wtsp_pkg::div_side_t               in_side,
  input  logic [wtsp_pkg::MAG_BITS-1:0]     mag_x,
  input  logic [wtsp_pkg::MAG_BITS-1:0]     mag_y,
  input  logic [wtsp_pkg::MAG_BITS-1:0]     w,
  output logic                              out_valid,
  output wtsp_pkg::div_side_t               out_side,
  output logic [wtsp_pkg::Q_BITS-1:0]       q_x,
  output logic [wtsp_pkg::Q_BITS-1:0]       q_y
);

  localparam int NSTEP = wtsp_pkg::Q_BITS;
  localparam int MB    = wtsp_pkg::MAG_BITS;

  logic                      vs   [NSTEP+1];
  wtsp_pkg::div_side_t       ss   [NSTEP+1];
  logic [MB-1:0]             mxs  [NSTEP+1];
  logic [MB-1:0]             mys  [NSTEP+1];
  logic [MB-1:0]             ws   [NSTEP+1];
  logic [MB-1:0]             rxs  [NSTEP+1];
  logic [MB-1:0]             rys  [NSTEP+1];
  logic [NSTEP-1:0]          qxs  [NSTEP+1];
  logic [NSTEP-1:0]          qys  [NSTEP+1];

  // The dividend is mag << FRAC_BITS; its bits above the quotient range
  // seed the remainder.
  assign vs[0]  = in_valid;
  assign ss[0]  = in_side;
  assign mxs[0] = mag_x;
  assign mys[0] = mag_y;
  assign ws[0]  = w;
  assign rxs[0] = in_side.ovf_x ? '0 : {32'b0, mag_x[47:32]};
  assign rys[0] = in_side.ovf_y ? '0 : {32'b0, mag_y[47:32]};
  assign qxs[0] = '0;
  assign qys[0] = '0;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam int B = NSTEP - 1 - k;
    logic          dbx, dby, gex, gey;
    logic [MB:0]   tx, ty, dx, dy;
    logic [MB-1:0] rxn, ryn;
    logic [NSTEP-1:0] qxn, qyn;

    if (B >= wtsp_pkg::FRAC_BITS) begin : g_bit
      assign dbx = mxs[k][B-wtsp_pkg::FRAC_BITS];
      assign dby = mys[k][B-wtsp_pkg::FRAC_BITS];
    end else begin : g_zero
      assign dbx = 1'b0;
      assign dby = 1'b0;
    end

    always_comb begin
      tx  = {rxs[k], dbx};
      ty  = {rys[k], dby};
      dx  = tx - {1'b0, ws[k]};
      dy  = ty - {1'b0, ws[k]};
      gex = tx >= {1'b0, ws[k]};
      gey = ty >= {1'b0, ws[k]};
      rxn = gex ? dx[MB-1:0] : tx[MB-1:0];
      ryn = gey ? dy[MB-1:0] : ty[MB-1:0];
      qxn = qxs[k];
      qyn = qys[k];
      qxn[B] = gex;
      qyn[B] = gey;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ss[k+1]  <= ss[k];
        mxs[k+1] <= mxs[k];
        mys[k+1] <= mys[k];
        ws[k+1]  <= ws[k];
        rxs[k+1] <= rxn;
        rys[k+1] <= ryn;
        qxs[k+1] <= qxn;
        qys[k+1] <= qyn;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k+1] <= 1'b0;
      end else if (en) begin
        vs[k+1] <= vs[k];
      end
    end
  end

  assign out_valid = vs[NSTEP];
  assign out_side  = ss[NSTEP];
  assign q_x       = qxs[NSTEP];
  assign q_y       = qys[NSTEP];

endmodule

### hdl/wtsp_map.sv
// Viewport mapping: quotient clamp and sign, scale by the half extents,
// offset and saturation into the result register. Depends on wtsp_pkg.
module wtsp_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  wtsp_pkg::div_side_t               in_side,
  input  logic [wtsp_pkg::Q_BITS-1:0]       q_x,
  input  logic [wtsp_pkg::Q_BITS-1:0]       q_y,
  input  logic [wtsp_pkg::HALF_BITS-1:0]    hw,
  input  logic [wtsp_pkg::HALF_BITS-1:0]    hh,
  output logic                              out_valid,
  output wtsp_pkg::rsp_t                    out_item
);

  localparam logic [wtsp_pkg::Q_BITS-1:0] QCLAMP = 48'h8000_0000_0000;

  logic                                  v1, v2, on1, on2;
  logic signed [wtsp_pkg::NDC_BITS-1:0]  nx, ny;
  logic signed [63:0]                    px, py;
  logic [wtsp_pkg::Q_BITS-1:0]           cx, cy;
  logic signed [wtsp_pkg::NDC_BITS-1:0]  ux, uy;
  logic signed [64:0]                    sx, sy;

  always_comb begin
    cx = (in_side.ovf_x || q_x > QCLAMP) ? QCLAMP : q_x;
    cy = (in_side.ovf_y || q_y > QCLAMP) ? QCLAMP : q_y;
    ux = $signed({1'b0, cx});
    uy = $signed({1'b0, cy});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx  <= in_side.neg_x ? -ux : ux;
      ny  <= in_side.neg_y ? -uy : uy;
      on1 <= in_side.on;
      px  <= 64'($signed({1'b0, hw}) * nx);
      py  <= 64'($signed({1'b0, hh}) * ny);
      on2 <= on1;
    end
  end

  always_comb begin
    sx = 65'(px) + $signed({35'b0, hw, 16'b0});
    sy = $signed({35'b0, hh, 16'b0}) - 65'(py);
  end

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -65'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.on_screen <= on2;
      out_item.screen_x  <= on2 ? sat32(sx) : '0;
      out_item.screen_y  <= on2 ? sat32(sy) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

### hdl/world_to_screen_projection_core.sv
// Top level of the world-to-screen projection core: registers, handshake
// and the clip, divider and mapping pipeline. Depends on wtsp_pkg.
//
//   channel  signals                       direction  carries
//   req      req_valid, req_stall, req     in         matrix load or point
//   rsp      rsp_valid, rsp_stall, rsp     out        on_screen, screen x/y
//   cfg      cfg_valid, cfg_ready, index   in         viewport and near limit
//
// One item enters per cycle while the pipeline is not frozen; a point item's
// result passes through three clip stages, 48 divider stages (one quotient
// bit each) and three mapping stages. Load items write the matrix at acceptance and give no result.
// Reset is synchronous, clears the matrix and all valid bits, and sets the configuration registers to their defaults.
// When the result register holds an item that is stalled, the whole pipeline
// freezes and req_stall rises in the same cycle.
module world_to_screen_projection_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  wtsp_pkg::req_t       req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output wtsp_pkg::rsp_t       rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  wtsp_pkg::cfg_index_t cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [14:0] viewport_width;
  logic [14:0] viewport_height;
  logic [30:0] near_limit;

  // Registers are always writable; software must write them only while idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_width  <= 15'd1024;
      viewport_height <= 15'd768;
      near_limit      <= 31'd6554;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wtsp_pkg::CFG_VIEWPORT_WIDTH:  viewport_width  <= cfg_data[14:0];
        wtsp_pkg::CFG_VIEWPORT_HEIGHT: viewport_height <= cfg_data[14:0];
        wtsp_pkg::CFG_NEAR_LIMIT:      near_limit      <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the result register is empty or taken.
  logic advance, accept;
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = !advance;
  assign accept    = req_valid && advance;

  logic                              clip_valid;
  wtsp_pkg::div_side_t               clip_side;
  logic [wtsp_pkg::MAG_BITS-1:0]     mag_x, mag_y, w;

  wtsp_clip u_clip (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .load_en    (accept && req.kind == wtsp_pkg::KIND_LOAD),
    .load_index (req.matrix_index),
    .load_value (req.matrix_value),
    .in_valid   (accept && req.kind == wtsp_pkg::KIND_XFORM),
    .pos_x      (req.pos_x),
    .pos_y      (req.pos_y),
    .pos_z      (req.pos_z),
    .near_limit (near_limit),
    .out_valid  (clip_valid),
    .out_side   (clip_side),
    .out_mag_x  (mag_x),
    .out_mag_y  (mag_y),
    .out_w      (w)
  );

  logic                              div_valid;
  wtsp_pkg::div_side_t               div_side;
  logic [wtsp_pkg::Q_BITS-1:0]       q_x, q_y;

  wtsp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (clip_valid),
    .in_side   (clip_side),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .w         (w),
    .out_valid (div_valid),
    .out_side  (div_side),
    .q_x       (q_x),
    .q_y       (q_y)
  );

  wtsp_map u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (div_valid),
    .in_side   (div_side),
    .q_x       (q_x),
    .q_y       (q_y),
    .hw        (viewport_width[14:1]),
    .hh        (viewport_height[14:1]),
    .out_valid (rsp_valid),
    .out_item  (rsp)
  );

  // An off-screen result always carries zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.on_screen |-> rsp.screen_x == 0 && rsp.screen_y == 0)
    else $error("off-screen result with nonzero coordinates");

  // Input back-pressure comes only from a stalled, occupied result register.
  assert property (@(posedge clk)
    req_stall == (rsp_valid && rsp_stall))
    else $error("input stall does not follow the result register");

  // Reset leaves no result pending.
  assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule
